// ----- rtl/weighted_covariance_accumulator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the weighted covariance accumulator
// Shared forms for same-cycle and next-cycle implications.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_COVARIANCE_ACCUMULATOR_ASSERT_SVH
`define WEIGHTED_COVARIANCE_ACCUMULATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define WCA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wca port check failed");

// antecedent implies consequent in the next cycle
`define WCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wca port check failed");

`endif

// ----- rtl/wca_pkg.sv -----
// ----------------------------------------------------------------------------
// wca_pkg
// Types and constants shared by the covariance accumulator modules.
// ----------------------------------------------------------------------------
package wca_pkg;

   localparam int CFG_W    = 5;
   localparam int VALUE_W  = 16;
   localparam int WEIGHT_W = 16;
   localparam int IDX_W    = 4;
   localparam int SUM_W    = 64;
   localparam int WTOT_W   = 48;
   localparam int COUNT_W  = 32;
   localparam int COV_W    = 32;
   localparam int NUM_W    = 128;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_READ   = 1'b1;

   // one queued item, already classified
   typedef struct packed {
      logic                       opcode;
      logic signed [VALUE_W-1:0]  value;
      logic [WEIGHT_W-1:0]        weight;
      logic [IDX_W-1:0]           row_hi;
      logic [IDX_W-1:0]           col_lo;
   } item_type;

   // queue head seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   // back end status and pop toward the front end
   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctrl_type;

   typedef enum logic [3:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_ELEM,
      BK_ESUM,
      BK_PREAD,
      BK_PMUL,
      BK_PWRITE,
      BK_RREAD0,
      BK_RREAD1,
      BK_RREAD2,
      BK_RMULA,
      BK_RMULB,
      BK_RSUM,
      BK_RDIV1,
      BK_RDIV2,
      BK_RDONE
   } back_state_type;

endpackage

// ----- rtl/wca_div.sv -----
// ----------------------------------------------------------------------------
// wca_div
// Restoring divider, 128-bit dividend by 48-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module wca_div
   import wca_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_W-1:0]    dividend,
   input  logic [WTOT_W-1:0]   divisor,
   output logic                done,
   output logic [NUM_W-1:0]    quotient
);

   localparam int CNT_W = $clog2(NUM_W);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [WTOT_W-1:0] rem_ff;
   logic [WTOT_W-1:0] dsr_ff;
   logic [NUM_W-1:0]  quo_ff;

   logic [WTOT_W:0]   trial;
   logic [WTOT_W:0]   diff;
   logic              ge;

   // trial subtract of the next dividend bit
   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      ge    = trial >= {1'b0, dsr_ff};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath: dividend shifts out the top, quotient bits shift in below
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[WTOT_W-1:0] : trial[WTOT_W-1:0];
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/wca_front.sv -----
// ----------------------------------------------------------------------------
// wca_front
// Accepts request transfers, orders the read indexes, queues two items.
// ----------------------------------------------------------------------------
module wca_front
   import wca_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [39:0]   req_tdata,
   input  logic          req_tuser,
   input  back_ctrl_type ctrl,
   output head_type      head
);

   item_type   q_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;

   item_type   item_in;
   logic [IDX_W-1:0] row;
   logic [IDX_W-1:0] col;
   logic       push;
   logic       pop;

   // classify: unpack and put the larger index first
   always_comb begin
      row            = req_tdata[35:32];
      col            = req_tdata[39:36];
      item_in.opcode = req_tuser;
      item_in.value  = req_tdata[15:0];
      item_in.weight = req_tdata[31:16];
      item_in.row_hi = (row > col) ? row : col;
      item_in.col_lo = (row > col) ? col : row;
   end

   assign req_tready = (cnt_ff != 2'd2) && !ctrl.clearing;
   assign push       = req_tvalid && req_tready;
   assign pop        = ctrl.pop && (cnt_ff != 2'd0);

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= item_in;
   end

   assign head.valid = cnt_ff != 2'd0;
   assign head.item  = q_ff[rd_ptr_ff];

endmodule

// ----- rtl/wca_back.sv -----
// ----------------------------------------------------------------------------
// wca_back
// Sequencer for sums update and covariance read, with result register.
// ----------------------------------------------------------------------------
module wca_back
   import wca_pkg::*;
#(
   parameter int MAX_SIZE = 16
)
(
   input  logic                clock,
   input  logic                reset,
   input  head_type            head,
   output back_ctrl_type       ctrl,
   input  logic                csr_wr_en,
   input  logic [CFG_W-1:0]    csr_wr_data,
   output logic                rsp_valid,
   input  logic                rsp_tready,
   output logic [COV_W-1:0]    rsp_cov,
   output logic [COUNT_W-1:0]  rsp_count,
   output logic                rsp_flag
);

   localparam int PW         = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int PAIR_DEPTH = (MAX_SIZE * (MAX_SIZE + 1)) / 2;
   localparam int KW         = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
   localparam int RESET_VS   = (MAX_SIZE < 16) ? MAX_SIZE : 16;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0] a,
      input logic signed [SUM_W-1:0] b
   );
      logic signed [SUM_W:0] s;
      s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
      if (s[SUM_W] != s[SUM_W-1]) return s[SUM_W] ? SUM_MIN : SUM_MAX;
      return s[SUM_W-1:0];
   endfunction

   function automatic logic [SUM_W-1:0] mag(input logic signed [SUM_W-1:0] v);
      return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
   endfunction

   function automatic logic [NUM_W-1:0] pp_shift(input logic [63:0] p, input logic [1:0] s);
      logic [NUM_W-1:0] x;
      x = {64'd0, p};
      case (s)
         2'd0:    return x;
         2'd1:    return x << 32;
         2'd2:    return x << 32;
         default: return x << 64;
      endcase
   endfunction

   back_state_type state_ff, state_in;

   // control state
   logic [CFG_W-1:0]    vs_ff;
   logic [PW-1:0]       pos_ff;
   logic [WEIGHT_W-1:0] vw_ff;
   logic [WTOT_W-1:0]   wtot_ff;
   logic [COUNT_W-1:0]  vcnt_ff;
   logic [KW-1:0]       clr_ff;
   logic [2:0]          mstep_ff;
   logic                rsp_valid_ff;

   // payload
   logic signed [VALUE_W-1:0] cur_x_ff;
   logic [PW-1:0]             p_ff;
   logic [PW-1:0]             j_ff;
   logic [KW-1:0]             k_ff;
   logic signed [32:0]        xw_ff;
   logic signed [48:0]        prod_ff;
   logic [IDX_W-1:0]          r_ff;
   logic [IDX_W-1:0]          c_ff;
   logic signed [SUM_W-1:0]   sxy_ff, sx_ff, sy_ff;
   logic [63:0]               pp_ff;
   logic [1:0]                pidx_ff;
   logic [NUM_W-1:0]          acc_ff, a_ff, b_ff;
   logic                      neg_ff;
   logic [COV_W-1:0]          value_ff;
   logic                      flag_ff;
   logic [COV_W-1:0]          rsp_cov_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic                      rsp_flag_ff;

   // memories
   logic signed [SUM_W-1:0]   pair_mem_ff [PAIR_DEPTH];
   logic signed [SUM_W-1:0]   es_mem_ff [MAX_SIZE];
   logic signed [VALUE_W-1:0] cv_mem_ff [MAX_SIZE];
   logic signed [SUM_W-1:0]   pair_rd_ff, es_rd_ff;
   logic signed [VALUE_W-1:0] cv_rd_ff;

   logic                    pair_we, es_we, cv_we;
   logic [KW-1:0]           pair_waddr, pair_raddr;
   logic [PW-1:0]           es_waddr, es_raddr, cv_raddr;
   logic signed [SUM_W-1:0] pair_wdata, es_wdata;

   // decode of the queue head
   logic [PW-1:0]       p_eff;
   logic [WEIGHT_W-1:0] w_eff;
   logic                r_ok;
   logic                w_zero;
   logic                out_free;
   logic                clr_last;

   // multiply and divide datapath
   logic [SUM_W-1:0]    mul_a, mul_b;
   logic [31:0]         a_part, b_part;
   logic [NUM_W-1:0]    mul_final;
   logic [NUM_W-1:0]    num, num_mag;
   logic signed [VALUE_W-1:0] y_val;
   logic                div_start, div_done;
   logic [NUM_W-1:0]    div_dividend, div_quo;
   logic [COV_W-1:0]    sat_val;

   always_comb begin
      if ((32'(pos_ff) < 32'(vs_ff)) && (32'(pos_ff) < MAX_SIZE)) p_eff = pos_ff;
      else p_eff = '0;
      w_eff    = (p_eff == '0) ? head.item.weight : vw_ff;
      r_ok     = (32'(head.item.row_hi) < 32'(vs_ff)) && (32'(head.item.row_hi) < MAX_SIZE);
      w_zero   = wtot_ff == '0;
      out_free = !rsp_valid_ff || rsp_tready;
      clr_last = 32'(clr_ff) == PAIR_DEPTH - 1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR:  if (clr_last) state_in = BK_IDLE;
         BK_IDLE: begin
            if (head.valid) begin
               if (head.item.opcode == OP_SAMPLE) state_in = BK_ELEM;
               else if (w_zero || !r_ok) state_in = BK_RDONE;
               else state_in = BK_RREAD0;
            end
         end
         BK_ELEM:   state_in = BK_ESUM;
         BK_ESUM:   state_in = BK_PREAD;
         BK_PREAD:  state_in = BK_PMUL;
         BK_PMUL:   state_in = BK_PWRITE;
         BK_PWRITE: state_in = (j_ff == p_ff) ? BK_IDLE : BK_PREAD;
         BK_RREAD0: state_in = BK_RREAD1;
         BK_RREAD1: state_in = BK_RREAD2;
         BK_RREAD2: state_in = BK_RMULA;
         BK_RMULA:  if (mstep_ff == 3'd4) state_in = BK_RMULB;
         BK_RMULB:  if (mstep_ff == 3'd4) state_in = BK_RSUM;
         BK_RSUM:   state_in = BK_RDIV1;
         BK_RDIV1:  if (div_done) state_in = BK_RDIV2;
         BK_RDIV2:  if (div_done) state_in = BK_RDONE;
         BK_RDONE:  if (out_free) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   // outputs of the sequencer: memory ports, pop, divider start
   always_comb begin
      ctrl.pop      = (state_ff == BK_IDLE) && head.valid;
      ctrl.clearing = state_ff == BK_CLEAR;
      pair_we       = 1'b0;
      pair_waddr    = k_ff;
      pair_wdata    = sat_add(pair_rd_ff, 64'(prod_ff));
      pair_raddr    = k_ff;
      es_we         = 1'b0;
      es_waddr      = p_ff;
      es_wdata      = sat_add(es_rd_ff, 64'(xw_ff));
      es_raddr      = p_ff;
      cv_we         = 1'b0;
      cv_raddr      = j_ff;
      div_start     = 1'b0;
      case (state_ff)
         BK_CLEAR: begin
            pair_we    = 1'b1;
            pair_waddr = clr_ff;
            pair_wdata = '0;
            es_we      = 32'(clr_ff) < MAX_SIZE;
            es_waddr   = PW'(clr_ff);
            es_wdata   = '0;
         end
         BK_ELEM:   cv_we = 1'b1;
         BK_ESUM:   es_we = 1'b1;
         BK_PWRITE: pair_we = 1'b1;
         BK_RREAD0: begin
            pair_raddr = KW'((32'(r_ff) * (32'(r_ff) + 32'd1)) / 2 + 32'(c_ff));
            es_raddr   = PW'(r_ff);
         end
         BK_RREAD1: es_raddr = PW'(c_ff);
         BK_RSUM:   div_start = 1'b1;
         BK_RDIV1:  div_start = div_done;
         default: begin
         end
      endcase
   end

   // memories with registered read data
   always_ff @(posedge clock) begin
      if (pair_we) pair_mem_ff[pair_waddr] <= pair_wdata;
      pair_rd_ff <= pair_mem_ff[pair_raddr];
   end

   always_ff @(posedge clock) begin
      if (es_we) es_mem_ff[es_waddr] <= es_wdata;
      es_rd_ff <= es_mem_ff[es_raddr];
   end

   always_ff @(posedge clock) begin
      if (cv_we) cv_mem_ff[p_ff] <= cur_x_ff;
      cv_rd_ff <= cv_mem_ff[cv_raddr];
   end

   // multiplier operands, quarter products
   always_comb begin
      mul_a     = (state_ff == BK_RMULB) ? mag(sx_ff) : mag(sxy_ff);
      mul_b     = (state_ff == BK_RMULB) ? mag(sy_ff) : {16'd0, wtot_ff};
      a_part    = mstep_ff[0] ? mul_a[63:32] : mul_a[31:0];
      b_part    = mstep_ff[1] ? mul_b[63:32] : mul_b[31:0];
      mul_final = acc_ff + pp_shift(pp_ff, pidx_ff);
      num       = a_ff + b_ff;
      num_mag   = num[NUM_W-1] ? NUM_W'(-num) : num;
      y_val     = (j_ff == p_ff) ? cur_x_ff : cv_rd_ff;
      div_dividend = (state_ff == BK_RSUM) ? num_mag : div_quo;
   end

   // saturate quotient to signed Q16.16
   always_comb begin
      if (neg_ff) begin
         if (div_quo[NUM_W-1:31] != '0) sat_val = 32'h8000_0000;
         else sat_val = 32'(-div_quo[31:0]);
      end else begin
         if (div_quo[NUM_W-1:31] != '0) sat_val = 32'h7FFF_FFFF;
         else sat_val = div_quo[31:0];
      end
   end

   wca_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (wtot_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         vs_ff        <= CFG_W'(RESET_VS);
         pos_ff       <= '0;
         vw_ff        <= '0;
         wtot_ff      <= '0;
         vcnt_ff      <= '0;
         clr_ff       <= '0;
         mstep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_CLEAR) clr_ff <= clr_ff + 1'b1;

         // register write restarts the vector
         if (csr_wr_en) begin
            if (csr_wr_data == '0) vs_ff <= CFG_W'(1);
            else if (32'(csr_wr_data) > MAX_SIZE) vs_ff <= CFG_W'(MAX_SIZE);
            else vs_ff <= csr_wr_data;
            pos_ff <= '0;
         end

         if (state_ff == BK_IDLE && head.valid && head.item.opcode == OP_SAMPLE &&
             p_eff == '0)
            vw_ff <= head.item.weight;

         // end of element: advance position, close vector
         if (state_ff == BK_PWRITE && j_ff == p_ff) begin
            if (32'(p_ff) + 32'd1 >= 32'(vs_ff)) begin
               wtot_ff <= ((49'(wtot_ff) + 49'(vw_ff)) > 49'({WTOT_W{1'b1}})) ?
                          {WTOT_W{1'b1}} : wtot_ff + WTOT_W'(vw_ff);
               if (vcnt_ff != '1) vcnt_ff <= vcnt_ff + 1'b1;
               pos_ff <= '0;
            end else begin
               pos_ff <= p_ff + 1'b1;
            end
         end

         if (state_ff == BK_RREAD2) mstep_ff <= '0;
         else if (state_ff == BK_RMULA || state_ff == BK_RMULB)
            mstep_ff <= (mstep_ff == 3'd4) ? 3'd0 : mstep_ff + 3'd1;

         if (state_ff == BK_RDONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            cur_x_ff <= head.item.value;
            p_ff     <= p_eff;
            xw_ff    <= head.item.value * $signed({1'b0, w_eff});
            r_ff     <= head.item.row_hi;
            c_ff     <= head.item.col_lo;
            value_ff <= '0;
            flag_ff  <= w_zero;
         end
         BK_ESUM: begin
            j_ff <= '0;
            k_ff <= KW'((32'(p_ff) * (32'(p_ff) + 32'd1)) / 2);
         end
         BK_PMUL:   prod_ff <= xw_ff * y_val;
         BK_PWRITE: begin
            j_ff <= j_ff + 1'b1;
            k_ff <= k_ff + 1'b1;
         end
         BK_RREAD1: begin
            sxy_ff <= pair_rd_ff;
            sx_ff  <= es_rd_ff;
         end
         BK_RREAD2: begin
            sy_ff  <= es_rd_ff;
            acc_ff <= '0;
         end
         BK_RMULA, BK_RMULB: begin
            pp_ff   <= {32'd0, a_part} * {32'd0, b_part};
            pidx_ff <= mstep_ff[1:0];
            if (mstep_ff == 3'd4) begin
               acc_ff <= '0;
               if (state_ff == BK_RMULA)
                  a_ff <= sxy_ff[SUM_W-1] ? NUM_W'(-mul_final) : mul_final;
               else
                  b_ff <= (sx_ff[SUM_W-1] == sy_ff[SUM_W-1]) ? NUM_W'(-mul_final) :
                          mul_final;
            end else if (mstep_ff != 3'd0) begin
               acc_ff <= mul_final;
            end
         end
         BK_RSUM:   neg_ff <= num[NUM_W-1];
         BK_RDIV2:  if (div_done) value_ff <= sat_val;
         default: begin
         end
      endcase

      if (state_ff == BK_RDONE && out_free) begin
         rsp_cov_ff   <= value_ff;
         rsp_count_ff <= vcnt_ff;
         rsp_flag_ff  <= flag_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cov   = rsp_cov_ff;
   assign rsp_count = rsp_count_ff;
   assign rsp_flag  = rsp_flag_ff;

endmodule

// ----- rtl/weighted_covariance_accumulator.sv -----
// ----------------------------------------------------------------------------
// weighted_covariance_accumulator
// Weighted sample vector accumulator with covariance entry read-out.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// req_*     in         tvalid/tready      tdata: value, weight, row, col; tuser: opcode
// rsp_*     out        tvalid/tready      tdata: covariance, count; tuser: no_weight
// csr_*     in         wr_en, no wait     wr_data: vector_size
//
// A sample element at position p does one read-modify-write of a pair sum for
// each of its p+1 pairs, through the pair memory port.
// A covariance read of a valid entry with nonzero weight runs two 128-step serial
// divisions. After reset a clearing pass over MAX_SIZE*(MAX_SIZE+1)/2 pair sums
// (136 by default) zeroes the sums; req_tready stays low during it.
// A two-entry queue takes transfers while the sequencer works or rsp stalls, until full.
// ----------------------------------------------------------------------------
module weighted_covariance_accumulator
   import wca_pkg::*;
#(
   parameter int MAX_SIZE = 16
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [39:0]       req_tdata,    // sample_value, sample_weight, read_row, read_col
   input  logic              req_tuser,    // opcode
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [63:0]       rsp_tdata,    // covariance_value, vector_count
   output logic              rsp_tuser,    // no_weight
   input  logic              csr_wr_en,
   input  logic [CFG_W-1:0]  csr_wr_data
);

   back_ctrl_type        ctrl;
   head_type             head;
   logic [COV_W-1:0]     rsp_cov;
   logic [COUNT_W-1:0]   rsp_count;

   wca_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .ctrl       (ctrl),
      .head       (head)
   );

   wca_back #(
      .MAX_SIZE (MAX_SIZE)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .ctrl        (ctrl),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_cov     (rsp_cov),
      .rsp_count   (rsp_count),
      .rsp_flag    (rsp_tuser)
   );

   assign rsp_tdata = {rsp_count, rsp_cov};

endmodule

// ----- rtl/wca_checker.sv -----
// ----------------------------------------------------------------------------
// wca_checker
// Port-level checks for the covariance accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "weighted_covariance_accumulator_assert.svh"

module wca_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser
);

   logic rsp_stall;

   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // a stalled result transfer holds
   `WCA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable({rsp_tuser, rsp_tdata}))

   // zero total weight forces a zero covariance
   `WCA_ASSERT_SAME(a_no_weight_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[31:0] == 32'd0)

   // clearing pass: no transfer taken right after reset
   `WCA_ASSERT_SAME(a_clear_blocks, clock, reset, $past(reset), !req_tready)

endmodule

bind weighted_covariance_accumulator wca_checker u_wca_checker (.*);
